FILE: rtl/assert_macros.svh
// Assertion macros for the ordered list core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define POL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define POL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define POL_ASSERT(lbl, clk, rst_n, prop, msg)
`define POL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/pol_pkg.sv
// Types and constants for the ordered list core.
package pol_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_INS_POS  = 3'd2,
		OP_DEL_HEAD = 3'd3,
		OP_DEL_TAIL = 3'd4,
		OP_DEL_POS  = 3'd5,
		OP_SEARCH   = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_TAKE,
		S_SCAN_RD,
		S_SCAN_CMP
	} state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
		logic [7:0]         position;
	} in_t;

	typedef struct packed {
		status_t    status;
		logic       found;
		logic [6:0] found_position;
		logic [6:0] length;
	} out_t;

endpackage

FILE: rtl/positional_ordered_list_core.sv
// Ordered list of signed values with positional insert, delete and search.
//
// Usage:
//   A command is transferred on the rising edge where start is high and busy
//   is low. busy stays high until the command is finished; then done pulses
//   for one cycle with the result (status, found, found_position, length).
//   Entries live in a single-port-read, single-port-write memory with
//   registered read data; every entry move or compare takes a read state
//   followed by a write or compare state.
//   Inserts pass through decide, a read and a write state per entry moved,
//   then put; deletes through decide, the same shift states, then take;
//   a search through decide, then a read and a compare state per entry.
//   A rejected command (full, empty, bad position), a search of an empty
//   list and op 7 finish in the decide state.
//   A new command is taken only while busy is low, so commands do not
//   overlap; the next one may be transferred in the done cycle itself,
//   since busy falls together with done.
//   Reset empties the list at once; entry contents are left as they are and
//   are never read beyond the current length. The result receiver cannot
//   stall: each result is flagged by done for exactly one cycle.
module positional_ordered_list_core #(
	parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pol_pkg::in_t   cmd,
	output logic           done,
	output pol_pkg::out_t  result
);

`include "assert_macros.svh"

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
	localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

	pol_pkg::state_t        state_q, state_d;
	pol_pkg::op_t           op_q;
	logic [DATA_WIDTH-1:0]  val_q;
	logic [7:0]             pos_q;
	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          cur_q, cur_d;
	logic [CW-1:0]          idx_q, idx_d;
	logic                   del_q, del_d;
	pol_pkg::out_t          res_q, res_d;
	logic                   done_q, done_d;

	logic [DATA_WIDTH-1:0]  mem [CAPACITY];
	logic [DATA_WIDTH-1:0]  rdata_q;
	logic [CW-1:0]          rd_idx;
	logic                   we;
	logic [CW-1:0]          wr_idx;
	logic [DATA_WIDTH-1:0]  wdata;

	logic signed [63:0]     val_ext;
	logic [CMPW-1:0]        pos_ext, cnt_ext;

	assign busy    = (state_q != pol_pkg::S_IDLE);
	assign done    = done_q;
	assign result  = res_q;
	assign val_ext = 64'(cmd.value);
	assign pos_ext = CMPW'(pos_q);
	assign cnt_ext = CMPW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pol_pkg::S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q  <= cmd.op;
			val_q <= val_ext[DATA_WIDTH-1:0];
			pos_q <= cmd.position;
		end
		cur_q <= cur_d;
		idx_q <= idx_d;
		del_q <= del_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx[AW-1:0]] <= wdata;
		end
		rdata_q <= mem[rd_idx[AW-1:0]];
	end

	always_comb begin
		logic [CW-1:0] tgt;
		logic          ok;
		tgt     = '0;
		ok      = 1'b1;
		state_d = state_q;
		count_d = count_q;
		cur_d   = cur_q;
		idx_d   = idx_q;
		del_d   = del_q;
		res_d   = res_q;
		done_d  = 1'b0;
		we      = 1'b0;
		wr_idx  = cur_q;
		wdata   = rdata_q;
		rd_idx  = cur_q;
		unique case (state_q)
			pol_pkg::S_IDLE: begin
				if (start) begin
					state_d = pol_pkg::S_DECIDE;
				end
			end
			pol_pkg::S_DECIDE: begin
				res_d.status         = pol_pkg::ST_OK;
				res_d.found          = 1'b0;
				res_d.found_position = '0;
				res_d.length         = 7'(count_q);
				unique case (op_q) inside
					pol_pkg::OP_INS_HEAD, pol_pkg::OP_INS_TAIL, pol_pkg::OP_INS_POS: begin
						if (count_q == CAP_CW) begin
							res_d.status = pol_pkg::ST_FULL;
							ok = 1'b0;
						end else if (op_q == pol_pkg::OP_INS_HEAD) begin
							tgt = '0;
						end else if (op_q == pol_pkg::OP_INS_TAIL) begin
							tgt = count_q;
						end else if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
							res_d.status = pol_pkg::ST_BADPOS;
							ok = 1'b0;
						end else begin
							tgt = CW'(pos_ext - 1'b1);
						end
						if (ok) begin
							idx_d   = tgt;
							cur_d   = count_q;
							del_d   = 1'b0;
							state_d = (count_q > tgt) ? pol_pkg::S_SHIFT_RD : pol_pkg::S_PUT;
						end else begin
							state_d = pol_pkg::S_IDLE;
							done_d  = 1'b1;
						end
					end
					pol_pkg::OP_DEL_HEAD, pol_pkg::OP_DEL_TAIL, pol_pkg::OP_DEL_POS: begin
						if (op_q == pol_pkg::OP_DEL_POS) begin
							if (pos_ext == '0 || pos_ext > cnt_ext) begin
								res_d.status = pol_pkg::ST_BADPOS;
								ok = 1'b0;
							end else begin
								tgt = CW'(pos_ext - 1'b1);
							end
						end else if (count_q == '0) begin
							res_d.status = pol_pkg::ST_EMPTY;
							ok = 1'b0;
						end else begin
							tgt = (op_q == pol_pkg::OP_DEL_HEAD) ? '0 : count_q - 1'b1;
						end
						if (ok) begin
							cur_d   = tgt;
							del_d   = 1'b1;
							state_d = ((CMPW'(tgt) + 1'b1) < cnt_ext) ? pol_pkg::S_SHIFT_RD
								: pol_pkg::S_TAKE;
						end else begin
							state_d = pol_pkg::S_IDLE;
							done_d  = 1'b1;
						end
					end
					pol_pkg::OP_SEARCH: begin
						cur_d = '0;
						if (count_q == '0) begin
							state_d = pol_pkg::S_IDLE;
							done_d  = 1'b1;
						end else begin
							state_d = pol_pkg::S_SCAN_RD;
						end
					end
					pol_pkg::OP_NOP: begin
						state_d = pol_pkg::S_IDLE;
						done_d  = 1'b1;
					end
				endcase
			end
			pol_pkg::S_SHIFT_RD: begin
				rd_idx  = del_q ? cur_q + 1'b1 : cur_q - 1'b1;
				state_d = pol_pkg::S_SHIFT_WR;
			end
			pol_pkg::S_SHIFT_WR: begin
				we = 1'b1;
				if (del_q) begin
					cur_d   = cur_q + 1'b1;
					state_d = ((CMPW'(cur_q) + 2'd2) < cnt_ext) ? pol_pkg::S_SHIFT_RD
						: pol_pkg::S_TAKE;
				end else begin
					cur_d   = cur_q - 1'b1;
					state_d = ((cur_q - 1'b1) > idx_q) ? pol_pkg::S_SHIFT_RD : pol_pkg::S_PUT;
				end
			end
			pol_pkg::S_PUT: begin
				we           = 1'b1;
				wr_idx       = idx_q;
				wdata        = val_q;
				count_d      = count_q + 1'b1;
				res_d.length = 7'(count_q + 1'b1);
				state_d      = pol_pkg::S_IDLE;
				done_d       = 1'b1;
			end
			pol_pkg::S_TAKE: begin
				count_d      = count_q - 1'b1;
				res_d.length = 7'(count_q - 1'b1);
				state_d      = pol_pkg::S_IDLE;
				done_d       = 1'b1;
			end
			pol_pkg::S_SCAN_RD: begin
				state_d = pol_pkg::S_SCAN_CMP;
			end
			pol_pkg::S_SCAN_CMP: begin
				if (rdata_q == val_q) begin
					res_d.found          = 1'b1;
					res_d.found_position = 7'(cur_q + 1'b1);
					state_d              = pol_pkg::S_IDLE;
					done_d               = 1'b1;
				end else if ((CMPW'(cur_q) + 1'b1) < cnt_ext) begin
					cur_d   = cur_q + 1'b1;
					state_d = pol_pkg::S_SCAN_RD;
				end else begin
					state_d = pol_pkg::S_IDLE;
					done_d  = 1'b1;
				end
			end
		endcase
	end

	`POL_ASSERT_IMP(a_start_busy, clk, arst_n, start && !busy, ##1 busy, "transfer did not raise busy")
	`POL_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "done while still busy")
	`POL_ASSERT_IMP(a_done_len, clk, arst_n, done, result.length == 7'(count_q), "length mismatch")
	`POL_ASSERT(a_cnt_cap, clk, arst_n, count_q <= CAP_CW, "entry count above capacity")
	`POL_ASSERT_IMP(a_we_busy, clk, arst_n, we, busy, "memory write while idle")

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the ordered list core: directed and random commands against a predictor.
module tb_top;

	localparam int CAP        = pol_pkg::CAPACITY_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_ITEMS = 1925;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	pol_pkg::in_t  cmd = '0;
	logic          busy;
	logic          done;
	pol_pkg::out_t result;

	positional_ordered_list_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	pol_pkg::in_t  pending_cmds[$];
	pol_pkg::out_t expected_results[$];
	logic [31:0]   list_mirror[$];
	logic [31:0]   value_pool[8];
	pol_pkg::out_t want_r;
	bit            accepted = 1'b0;
	int            mismatches = 0;
	int            idle_cycles = 0;
	int            burst_left = 1;
	int            gap_left = 0;
	int            gen_len = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// Expected outcome of one command; updates the mirrored list.
	function automatic pol_pkg::out_t list_apply(pol_pkg::in_t c);
		pol_pkg::out_t r;
		int            n;
		bit            hit;
		r = '0;
		r.status = pol_pkg::ST_OK;
		n = list_mirror.size();
		hit = 1'b0;
		case (c.op) inside
			pol_pkg::OP_INS_HEAD, pol_pkg::OP_INS_TAIL, pol_pkg::OP_INS_POS: begin
				if (n >= CAP)
					r.status = pol_pkg::ST_FULL;
				else if (c.op == pol_pkg::OP_INS_HEAD)
					list_mirror.push_front(c.value);
				else if (c.op == pol_pkg::OP_INS_TAIL)
					list_mirror.push_back(c.value);
				else if (c.position < 1 || c.position > n + 1)
					r.status = pol_pkg::ST_BADPOS;
				else
					list_mirror.insert(c.position - 1, c.value);
			end
			pol_pkg::OP_DEL_HEAD, pol_pkg::OP_DEL_TAIL: begin
				if (n == 0)
					r.status = pol_pkg::ST_EMPTY;
				else if (c.op == pol_pkg::OP_DEL_HEAD)
					void'(list_mirror.pop_front());
				else
					void'(list_mirror.pop_back());
			end
			pol_pkg::OP_DEL_POS: begin
				if (n == 0 || c.position < 1 || c.position > n)
					r.status = pol_pkg::ST_BADPOS;
				else
					list_mirror.delete(c.position - 1);
			end
			pol_pkg::OP_SEARCH: begin
				for (int i = 0; i < n; i++) begin
					if (!hit && list_mirror[i] == c.value) begin
						hit = 1'b1;
						r.found = 1'b1;
						r.found_position = 7'(i + 1);
					end
				end
			end
			default: ;
		endcase
		r.length = 7'(list_mirror.size());
		return r;
	endfunction

	// Queues one command and tracks the list length the stream will produce.
	task automatic queue_cmd(pol_pkg::op_t op, logic [31:0] value, int pos);
		pol_pkg::in_t c;
		c.op = op;
		c.value = value;
		c.position = 8'(pos);
		pending_cmds.push_back(c);
		case (op) inside
			pol_pkg::OP_INS_HEAD, pol_pkg::OP_INS_TAIL, pol_pkg::OP_INS_POS: begin
				if (gen_len < CAP
					&& (op != pol_pkg::OP_INS_POS || (pos >= 1 && pos <= gen_len + 1)))
					gen_len++;
				if ($urandom_range(0, 3) == 0)
					value_pool[$urandom_range(4, 7)] = value;
			end
			pol_pkg::OP_DEL_HEAD, pol_pkg::OP_DEL_TAIL: if (gen_len > 0) gen_len--;
			pol_pkg::OP_DEL_POS: if (pos >= 1 && pos <= gen_len) gen_len--;
			default: ;
		endcase
	endtask

	// Driver: presents the next queued command once the current one is transferred.
	always @(negedge clk) begin
		if (arst_n && (!start || accepted)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds.pop_front();
				start <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each result, then predicts for a new transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			accepted = start && !busy;
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", int'(result.length), 0);
				end else begin
					want_r = expected_results.pop_front();
					if (result.status !== want_r.status)
						report_mismatch("status", int'(result.status), int'(want_r.status));
					if (result.found !== want_r.found)
						report_mismatch("found", int'(result.found), int'(want_r.found));
					if (result.found_position !== want_r.found_position)
						report_mismatch("found_position", int'(result.found_position),
							int'(want_r.found_position));
					if (result.length !== want_r.length)
						report_mismatch("length", int'(result.length), int'(want_r.length));
				end
			end
			if (accepted)
				expected_results.push_back(list_apply(cmd));
			if (accepted || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int           n_rand;
		int           seg;
		int           seg_len;
		int           roll;
		int           pos;
		pol_pkg::op_t op;
		logic [31:0]  val;

		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		// directed: empty list, range edges, duplicates, extremes
		queue_cmd(pol_pkg::OP_DEL_HEAD, 0, 0);
		queue_cmd(pol_pkg::OP_DEL_TAIL, 0, 0);
		queue_cmd(pol_pkg::OP_DEL_POS, 0, 1);
		queue_cmd(pol_pkg::OP_DEL_POS, 0, 0);
		queue_cmd(pol_pkg::OP_SEARCH, 0, 0);
		queue_cmd(pol_pkg::OP_INS_POS, 32'h1, 0);
		queue_cmd(pol_pkg::OP_INS_POS, 32'h2, 2);
		queue_cmd(pol_pkg::OP_INS_POS, 32'h8000_0000, 1);
		queue_cmd(pol_pkg::OP_INS_HEAD, 32'h7fff_ffff, 0);
		queue_cmd(pol_pkg::OP_INS_TAIL, 32'h0, 255);
		queue_cmd(pol_pkg::OP_INS_POS, 32'hffff_ffff, 4);
		queue_cmd(pol_pkg::OP_INS_POS, 32'h5, 2);
		queue_cmd(pol_pkg::OP_INS_POS, 32'h6, 255);
		queue_cmd(pol_pkg::OP_SEARCH, 32'hffff_ffff, 0);
		queue_cmd(pol_pkg::OP_SEARCH, 32'h7fff_ffff, 255);
		queue_cmd(pol_pkg::OP_SEARCH, 32'd12345, 0);
		queue_cmd(pol_pkg::OP_INS_TAIL, 32'h5, 0);
		queue_cmd(pol_pkg::OP_SEARCH, 32'h5, 0);
		queue_cmd(pol_pkg::OP_NOP, 32'hffff_ffff, 255);
		queue_cmd(pol_pkg::OP_DEL_POS, 0, 0);
		queue_cmd(pol_pkg::OP_DEL_POS, 0, 7);
		queue_cmd(pol_pkg::OP_DEL_POS, 0, 255);
		queue_cmd(pol_pkg::OP_DEL_POS, 0, 3);
		queue_cmd(pol_pkg::OP_DEL_HEAD, 0, 0);
		queue_cmd(pol_pkg::OP_DEL_TAIL, 0, 0);

		// random: alternating fill, drain and mixed segments
		n_rand = 0;
		seg = 0;
		while (n_rand < RAND_ITEMS) begin
			seg_len = $urandom_range(40, 160);
			for (int k = 0; k < seg_len && n_rand < RAND_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				case (seg % 3)
					0: roll = (roll < 75) ? 0 : (roll < 85) ? 1 : (roll < 97) ? 2 : 3;
					1: roll = (roll < 15) ? 0 : (roll < 85) ? 1 : (roll < 97) ? 2 : 3;
					default: roll = (roll < 40) ? 0 : (roll < 80) ? 1 : (roll < 97) ? 2 : 3;
				endcase
				case (roll)
					0: op = pol_pkg::op_t'(3'($urandom_range(0, 2)));
					1: op = pol_pkg::op_t'(3'($urandom_range(3, 5)));
					2: op = pol_pkg::OP_SEARCH;
					default: op = pol_pkg::OP_NOP;
				endcase
				val = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
				case ($urandom_range(0, 7))
					0: pos = 0;
					1: pos = 1;
					2: pos = gen_len;
					3: pos = gen_len + 1;
					4: pos = gen_len + 2;
					5, 6: pos = $urandom_range(1, gen_len + 1);
					default: pos = $urandom_range(0, 255);
				endcase
				queue_cmd(op, val, pos);
				n_rand++;
			end
			seg++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (2 * CAP + 8) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: positional_ordered_list_core.f
+incdir+rtl
rtl/pol_pkg.sv
rtl/positional_ordered_list_core.sv
bench/tb_top.sv
